FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the frame engine.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define LMFE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define LMFE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/lmfe_pkg.sv
// Shared types, constants and functions of the LIN master frame engine.
// No dependencies; used by every module of the block but lmfe_ram.
package lmfe_pkg;

  localparam int ID_W    = 6;
  localparam int BYTE_W  = 8;
  localparam int DATA_W  = 64;
  localparam int LEN_W   = 4;
  localparam int MASK_W  = 64;

  // Stream widths: input {rx_byte, req_id}, output {len, data, id, tx}
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_PAD_W  = OUT_DATA_W - (BYTE_W + ID_W + DATA_W + LEN_W);

  localparam int QUEUE_DEPTH_DEF = 8;

  // Descriptor queue between front and back
  localparam int DESC_DEPTH = 2;
  localparam int DESC_PW    = 1;
  localparam int DESC_CW    = 2;

  // Header bytes
  localparam logic [BYTE_W-1:0] HDR_BREAK = 8'h00;
  localparam logic [BYTE_W-1:0] HDR_SYNC  = 8'h55;

  // Input item kinds
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RX_BYTE = 1'b1;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  // Result sequencer steps of the back end
  typedef enum logic [1:0] {
    STEP_FRAME,
    STEP_BREAK,
    STEP_SYNC,
    STEP_PID
  } lmfe_step_t;

  // Work handed from front to back: an optional frame, then an optional header
  typedef struct packed {
    logic              frame_ok;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] frame_data;
    logic [LEN_W-1:0]  data_len;
    logic              hdr_ok;
    logic [ID_W-1:0]   hdr_id;
  } lmfe_desc_t;

  // Response length selected by the two low ID bits
  function automatic logic [LEN_W-1:0] len_of(input logic [ID_W-1:0] id);
    logic [LEN_W-1:0] len;
    case (id[1:0])
      2'd3:    len = 4'd8;
      2'd2:    len = 4'd4;
      default: len = 4'd2;
    endcase
    return len;
  endfunction

  // Protected identifier: ID in bits 7:2, parity P1 in bit 1, P0 in bit 0
  function automatic logic [BYTE_W-1:0] protected_id(input logic [ID_W-1:0] id);
    logic p1;
    logic p0;
    p1 = id[5] ^ id[4] ^ id[3] ^ id[1];
    p0 = id[4] ^ id[2] ^ id[1] ^ id[0];
    return {id, p1, p0};
  endfunction

endpackage

FILE: hdl/lmfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and read-first registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/lmfe_front.sv
// Front end: accepts requests and bus bytes, keeps the request queue and
// frame state, and hands result descriptors to the back end. Uses lmfe_pkg, lmfe_ram.
module lmfe_front #(
  parameter int QUEUE_DEPTH = lmfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lmfe_pkg::MASK_W-1:0]    cfg_wdata,
  input  logic                           fire,
  input  logic                           action,
  input  logic [lmfe_pkg::ID_W-1:0]      req_id,
  input  logic [lmfe_pkg::BYTE_W-1:0]    rx_byte,
  output logic                           desc_push,
  output lmfe_pkg::lmfe_desc_t           desc
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = ((IW > CW) ? IW : CW) + 1;
  localparam int ID_W = lmfe_pkg::ID_W;
  localparam int BYTE_W = lmfe_pkg::BYTE_W;
  localparam int DATA_W = lmfe_pkg::DATA_W;
  localparam int LEN_W = lmfe_pkg::LEN_W;

  logic [lmfe_pkg::MASK_W-1:0] mask_r;
  logic [IW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              busy_r, busy_nxt;
  logic [ID_W-1:0]   cur_id_r, cur_id_nxt;
  logic [LEN_W-1:0]  bytes_r, bytes_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              byp_r;
  logic [ID_W-1:0]   byp_data_r;

  logic [SW-1:0]     tail_sum;
  logic [IW-1:0]     tail;
  logic [IW-1:0]     head_inc;
  logic              wr_en;
  logic [ID_W-1:0]   ram_rdata;
  logic [ID_W-1:0]   head_id;
  logic [LEN_W-1:0]  cur_len;

  // Queue positions
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : IW'(tail_sum);
  assign head_inc = (head_r == IW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // Request queue storage, read address follows the next head
  lmfe_ram #(
    .WIDTH (ID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (req_id),
    .rd_addr (head_nxt),
    .rd_data (ram_rdata)
  );

  // Forward a write that hit the head address in the same cycle
  assign head_id = byp_r ? byp_data_r : ram_rdata;
  assign cur_len = lmfe_pkg::len_of(cur_id_r);

  // Classify the item and update frame state
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    busy_nxt   = busy_r;
    cur_id_nxt = cur_id_r;
    bytes_nxt  = bytes_r;
    data_nxt   = data_r;
    sum_nxt    = sum_r;
    wr_en      = 1'b0;
    desc       = '0;
    if (fire) begin
      if (action == lmfe_pkg::ACT_REQUEST) begin
        if (mask_r[req_id] && (count_r < CW'(QUEUE_DEPTH))) begin
          if (!busy_r) begin
            // idle means the queue is empty: start this ID at once
            busy_nxt    = 1'b1;
            cur_id_nxt  = req_id;
            bytes_nxt   = '0;
            data_nxt    = '0;
            sum_nxt     = '0;
            desc.hdr_ok = 1'b1;
            desc.hdr_id = req_id;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
      end else if (busy_r) begin
        if (bytes_r < cur_len) begin
          // collect a data byte into its lane
          for (int l = 0; l < 8; l++) begin
            if (bytes_r[2:0] == 3'(l)) begin
              data_nxt[l*BYTE_W +: BYTE_W] = rx_byte;
            end
          end
          sum_nxt   = sum_r + rx_byte;
          bytes_nxt = bytes_r + 1'b1;
        end else begin
          // checksum byte: emit on match, then go idle
          if (sum_r == rx_byte) begin
            desc.frame_ok   = 1'b1;
            desc.frame_id   = cur_id_r;
            desc.frame_data = data_r;
            desc.data_len   = cur_len;
          end
          busy_nxt  = 1'b0;
          bytes_nxt = '0;
          data_nxt  = '0;
          sum_nxt   = '0;
          // start the next queued ID
          if (count_r != '0) begin
            head_nxt    = head_inc;
            count_nxt   = count_r - 1'b1;
            busy_nxt    = 1'b1;
            cur_id_nxt  = head_id;
            desc.hdr_ok = 1'b1;
            desc.hdr_id = head_id;
          end
        end
      end
    end
    desc_push = desc.frame_ok | desc.hdr_ok;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      head_r   <= '0;
      count_r  <= '0;
      busy_r   <= 1'b0;
      cur_id_r <= '0;
      bytes_r  <= '0;
      data_r   <= '0;
      sum_r    <= '0;
      byp_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      busy_r   <= busy_nxt;
      cur_id_r <= cur_id_nxt;
      bytes_r  <= bytes_nxt;
      data_r   <= data_nxt;
      sum_r    <= sum_nxt;
      byp_r    <= wr_en && (tail == head_nxt);
    end
  end

  // Bypass data needs no reset
  always_ff @(posedge clk) begin
    byp_data_r <= req_id;
  end

endmodule

FILE: hdl/lmfe_desc_fifo.sv
// Short descriptor queue between front and back end.
// Uses lmfe_pkg.
module lmfe_desc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lmfe_pkg::lmfe_desc_t push_desc,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output lmfe_pkg::lmfe_desc_t pop_desc
);

  localparam int PW = lmfe_pkg::DESC_PW;
  localparam int CW = lmfe_pkg::DESC_CW;

  lmfe_pkg::lmfe_desc_t entry_r [lmfe_pkg::DESC_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(lmfe_pkg::DESC_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_desc = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
  end

  // Hold the entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: hdl/lmfe_back.sv
// Back end: walks each descriptor and drives one result per cycle into
// the output register unless a low out_tready stalls it. Uses lmfe_pkg.
module lmfe_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  lmfe_pkg::lmfe_desc_t              q_desc,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lmfe_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);

  lmfe_pkg::lmfe_step_t step_r, step_nxt;
  lmfe_pkg::lmfe_desc_t cur_r, cur_nxt;
  logic cur_valid_r, cur_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_kind_r, out_kind_nxt;
  logic out_last_r, out_last_nxt;
  logic [lmfe_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic load;
  logic finish;

  assign load = !out_valid_r || out_tready;

  // Sequence results and refill from the queue
  always_comb begin
    step_nxt      = step_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    finish        = 1'b0;
    q_pop         = 1'b0;
    if (load && cur_valid_r) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = lmfe_pkg::KIND_HEADER;
      out_last_nxt  = 1'b0;
      out_data_nxt  = '0;
      case (step_r)
        lmfe_pkg::STEP_FRAME: begin
          out_kind_nxt = lmfe_pkg::KIND_FRAME;
          out_data_nxt = {{lmfe_pkg::OUT_PAD_W{1'b0}}, cur_r.data_len, cur_r.frame_data,
                          cur_r.frame_id, lmfe_pkg::BYTE_W'(0)};
          out_last_nxt = !cur_r.hdr_ok;
          if (cur_r.hdr_ok) begin
            step_nxt = lmfe_pkg::STEP_BREAK;
          end else begin
            finish = 1'b1;
          end
        end
        lmfe_pkg::STEP_BREAK: begin
          out_data_nxt[lmfe_pkg::BYTE_W-1:0] = lmfe_pkg::HDR_BREAK;
          step_nxt = lmfe_pkg::STEP_SYNC;
        end
        lmfe_pkg::STEP_SYNC: begin
          out_data_nxt[lmfe_pkg::BYTE_W-1:0] = lmfe_pkg::HDR_SYNC;
          step_nxt = lmfe_pkg::STEP_PID;
        end
        lmfe_pkg::STEP_PID: begin
          out_data_nxt[lmfe_pkg::BYTE_W-1:0] = lmfe_pkg::protected_id(cur_r.hdr_id);
          out_last_nxt = 1'b1;
          finish = 1'b1;
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
    if (!cur_valid_r || finish) begin
      q_pop         = q_valid;
      cur_valid_nxt = q_valid;
      if (q_valid) begin
        cur_nxt  = q_desc;
        step_nxt = q_desc.frame_ok ? lmfe_pkg::STEP_FRAME : lmfe_pkg::STEP_BREAK;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= lmfe_pkg::STEP_FRAME;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/lin_master_frame_engine_core.sv
// LIN master frame engine, top level.
// Uses lmfe_pkg, lmfe_front, lmfe_desc_fifo and lmfe_back.
//
// Usage:
//   Input stream carries frame requests (in_tuser = 0, ID in in_tdata[5:0])
//   and bytes read back from the bus (in_tuser = 1, byte in in_tdata[13:6]).
//   A request whose bit is set in the accept mask is queued; the engine sends
//   break, sync and protected-ID header bytes, then collects 2/2/4/8 data
//   bytes (by ID[1:0]) and a checksum byte, and reports the frame on a match.
//   The output stream carries header bytes (out_tuser = 0) and received frames
//   (out_tuser = 1); out_tlast marks the final result caused by one request.
//   cfg_we with cfg_wdata writes the 64-bit accept mask; write only while idle.
// Timing:
//   The front takes one request per cycle while its two-entry descriptor queue
//   has room. Results pass the descriptor queue, the current-descriptor and
//   output registers, then leave one per cycle while out_tready is high; a
//   request ending a frame and starting the next yields up to four results.
// Reset (rst_n low at a clock edge): accept mask cleared, request queue empty,
//   engine idle, no result pending.
// Stall: the output register holds its result while out_tready is low; the back
//   end waits, the descriptor queue fills and in_tready falls.
module lin_master_frame_engine_core #(
  parameter int QUEUE_DEPTH = lmfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [lmfe_pkg::MASK_W-1:0]       cfg_wdata,
  // request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lmfe_pkg::IN_DATA_W-1:0]    in_tdata,   // req_id[5:0], rx_byte[13:6], 0
  input  logic                              in_tuser,   // action
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lmfe_pkg::OUT_DATA_W-1:0]   out_tdata,  // tx_byte[7:0], frame_id[13:8],
                                                        // frame_data[77:14],
                                                        // data_len[81:78], 0
  output logic                              out_tuser,  // kind
  output logic                              out_tlast   // last
);

  lmfe_pkg::lmfe_desc_t push_desc, pop_desc;
  logic desc_push, desc_pop, desc_full, desc_valid;
  logic fire;

  assign in_tready = !desc_full;
  assign fire      = in_tvalid && in_tready;

  // Classify requests and track the frame
  lmfe_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .action    (in_tuser),
    .req_id    (in_tdata[lmfe_pkg::ID_W-1:0]),
    .rx_byte   (in_tdata[lmfe_pkg::ID_W +: lmfe_pkg::BYTE_W]),
    .desc_push (desc_push),
    .desc      (push_desc)
  );

  // Decouple front and back
  lmfe_desc_fifo u_desc_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_desc (push_desc),
    .full      (desc_full),
    .pop       (desc_pop),
    .valid     (desc_valid),
    .pop_desc  (pop_desc)
  );

  // Emit results
  lmfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (desc_valid),
    .q_desc     (pop_desc),
    .q_pop      (desc_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hdl/lmfe_checker.sv
// Port-level checks on the frame engine's result stream, bound to the top level.
// Uses lmfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lmfe_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lmfe_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // A stalled result holds
  `LMFE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // No result on the edge after a reset edge
  `LMFE_ASSERT_ALWAYS(a_out_reset, !rst_n |=> !out_tvalid, "result valid after reset")

  // Frames carry a legal length and no header byte
  `LMFE_ASSERT(a_frame_len, out_tvalid && out_tuser |-> (out_tdata[81:78] == 4'd2 || out_tdata[81:78] == 4'd4 || out_tdata[81:78] == 4'd8) && out_tdata[7:0] == 8'h00, "bad frame length")

  // Header results carry only the header byte
  `LMFE_ASSERT(a_hdr_clean, out_tvalid && !out_tuser |-> out_tdata[87:8] == '0, "header result not clean")

  // Short frames leave upper data bytes clear
  `LMFE_ASSERT(a_short_frame, out_tvalid && out_tuser && out_tdata[81:78] == 4'd2 |-> out_tdata[77:30] == '0, "short frame has upper data")

endmodule

bind lin_master_frame_engine_core lmfe_checker u_checker (.*);

FILE: dv/tb_lin_master_frame_engine_core.sv
`timescale 1ns / 100ps
// Self-checking bench for lin_master_frame_engine_core: drives frame requests and
// bus bytes, predicts header bytes and received frames, checks each result in order.
// Depends on lmfe_pkg and the core RTL only.
module tb_lin_master_frame_engine_core;

  localparam int BYTE_W     = lmfe_pkg::BYTE_W;
  localparam int ID_W       = lmfe_pkg::ID_W;
  localparam int DATA_W     = lmfe_pkg::DATA_W;
  localparam int LEN_W      = lmfe_pkg::LEN_W;
  localparam int MASK_W     = lmfe_pkg::MASK_W;
  localparam int IN_DATA_W  = lmfe_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = lmfe_pkg::OUT_DATA_W;

  localparam logic ACT_REQUEST = lmfe_pkg::ACT_REQUEST;
  localparam logic ACT_RX_BYTE = lmfe_pkg::ACT_RX_BYTE;
  localparam logic KIND_HEADER = lmfe_pkg::KIND_HEADER;
  localparam logic KIND_FRAME  = lmfe_pkg::KIND_FRAME;
  localparam logic [BYTE_W-1:0] HDR_BREAK = lmfe_pkg::HDR_BREAK;
  localparam logic [BYTE_W-1:0] HDR_SYNC  = lmfe_pkg::HDR_SYNC;

  localparam int CLK_HALF    = 4;
  localparam int FIFO_SLOTS  = 8;
  localparam int SETTLE      = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_CAP   = 40;

  // Result field offsets within out_tdata
  localparam int FID_LO  = BYTE_W;
  localparam int DATA_LO = BYTE_W + ID_W;
  localparam int LEN_LO  = DATA_LO + DATA_W;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] tx;
    logic [ID_W-1:0]   fid;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } lin_result_t;

  // How a directed row is checked: by the predictor, by values typed in the row, or (CHK_NONE) as giving no result
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HEADER, CHK_FRAME} row_chk_t;

  typedef struct packed {
    logic              act;
    logic [ID_W-1:0]   id;
    logic [BYTE_W-1:0] rx;
    logic [3:0]        rep;
    row_chk_t          chk;
    logic [BYTE_W-1:0] t_pid;
    logic [ID_W-1:0]   t_fid;
    logic [DATA_W-1:0] t_data;
    logic [LEN_W-1:0]  t_len;
  } stim_row_t;

  localparam int N_RESET_ROWS = 2;
  localparam int N_ROWS       = 23;

  // Directed requests; the first rows run with the mask as left by reset
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{ACT_REQUEST, 6'd63, 8'h00, 4'd1,  CHK_NONE,   8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'hA5, 4'd1,  CHK_NONE,   8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_REQUEST, 6'd0,  8'h00, 4'd1,  CHK_HEADER, 8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'hFF, 4'd2,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'hFE, 4'd1,  CHK_FRAME,  8'h00, 6'd0, 64'hFFFF, 4'd2},
    '{ACT_REQUEST, 6'd63, 8'h00, 4'd1,  CHK_HEADER, 8'hFC, 6'd0, 64'h0,    4'd0},
    '{ACT_REQUEST, 6'd5,  8'h00, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h00, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h80, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'hFF, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h7F, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h01, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h55, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'hAA, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h10, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h00, 4'd1,  CHK_HEADER, 8'h14, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h12, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h34, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h46, 4'd1,  CHK_FRAME,  8'h00, 6'd5, 64'h3412, 4'd2},
    '{ACT_REQUEST, 6'd2,  8'h00, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_REQUEST, 6'd46, 8'h00, 4'd10, CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'hC3, 4'd4,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0},
    '{ACT_RX_BYTE, 6'd0,  8'h0C, 4'd1,  CHK_MODEL,  8'h00, 6'd0, 64'h0,    4'd0}
  };

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [MASK_W-1:0]       cfg_wdata  = '0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;   // req_id, rx_byte, 0
  logic                    in_tuser   = 1'b0; // action
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;         // tx_byte, frame_id, frame_data, data_len, 0
  logic                    out_tuser;         // kind
  logic                    out_tlast;

  // Predicted engine state
  logic [MASK_W-1:0] mask_q = '0;
  logic [ID_W-1:0]   id_fifo [FIFO_SLOTS];
  int                fifo_cnt = 0;
  int                fifo_hd  = 0;
  bit                eng_busy = 1'b0;
  logic [ID_W-1:0]   cur_id   = '0;
  int                rx_cnt   = 0;
  logic [DATA_W-1:0] data_acc = '0;
  logic [BYTE_W-1:0] sum_acc  = '0;

  lin_result_t step_out [$];
  lin_result_t due_results [$];
  int          mismatch_cnt  = 0;
  int          items_done    = 0;
  int          cycle_cnt     = 0;
  bit          steady        = 1'b0;
  bit          hold_off_req  = 1'b0;

  lin_master_frame_engine_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Response bytes selected by the two low ID bits
  function automatic int bytes_for(input logic [ID_W-1:0] id);
    return (id[1:0] == 2'd3) ? 8 : (id[1:0] == 2'd2) ? 4 : 2;
  endfunction

  // ID with its two parity bits appended
  function automatic logic [BYTE_W-1:0] pid_for(input logic [ID_W-1:0] id);
    return {id, ^(id & 6'b111010), ^(id & 6'b010111)};
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] bus_byte();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Pick an ID the mask lets through, falling back to any ID
  function automatic logic [ID_W-1:0] accepted_id();
    logic [ID_W-1:0] id;
    id = '0;
    for (int k = 0; k < 64; k++) begin
      id = ID_W'($urandom_range(0, 63));
      if (mask_q[id]) return id;
    end
    return id;
  endfunction

  // Advance the predicted engine by one request; fills step_out with its results
  task automatic advance_lin_engine(input logic act, input logic [ID_W-1:0] id,
                                    input logic [BYTE_W-1:0] rx);
    lin_result_t res;
    step_out.delete();
    res = '0;
    if (act == ACT_REQUEST) begin
      if (mask_q[id] && fifo_cnt < FIFO_SLOTS) begin
        id_fifo[(fifo_hd + fifo_cnt) % FIFO_SLOTS] = id;
        fifo_cnt++;
      end
    end else if (eng_busy) begin
      if (rx_cnt < bytes_for(cur_id)) begin
        data_acc[8*rx_cnt +: 8] = rx;
        sum_acc += rx;
        rx_cnt++;
      end else begin
        // checksum byte: report on a match, drop silently otherwise
        if (sum_acc == rx) begin
          res.kind = KIND_FRAME;
          res.fid  = cur_id;
          res.data = data_acc;
          res.len  = LEN_W'(bytes_for(cur_id));
          step_out.push_back(res);
        end
        eng_busy = 1'b0;
      end
    end
    // start the next queued ID as soon as the engine is free
    if (!eng_busy && fifo_cnt > 0) begin
      cur_id   = id_fifo[fifo_hd];
      fifo_hd  = (fifo_hd + 1) % FIFO_SLOTS;
      fifo_cnt--;
      eng_busy = 1'b1;
      rx_cnt   = 0;
      data_acc = '0;
      sum_acc  = '0;
      res      = '0;
      res.kind = KIND_HEADER;
      res.tx   = HDR_BREAK;
      step_out.push_back(res);
      res.tx   = HDR_SYNC;
      step_out.push_back(res);
      res.tx   = pid_for(cur_id);
      step_out.push_back(res);
    end
    if (step_out.size() > 0) begin
      res      = step_out.pop_back();
      res.last = 1'b1;
      step_out.push_back(res);
    end
  endtask

  task automatic keep_prediction();
    foreach (step_out[k]) due_results.push_back(step_out[k]);
  endtask

  // Queue the results typed into a directed row
  task automatic queue_typed(input stim_row_t row);
    lin_result_t res;
    res = '0;
    case (row.chk)
      CHK_HEADER: begin
        res.kind = KIND_HEADER;
        res.tx   = HDR_BREAK;
        due_results.push_back(res);
        res.tx   = HDR_SYNC;
        due_results.push_back(res);
        res.tx   = row.t_pid;
        res.last = 1'b1;
        due_results.push_back(res);
      end
      CHK_FRAME: begin
        res.kind = KIND_FRAME;
        res.fid  = row.t_fid;
        res.data = row.t_data;
        res.len  = row.t_len;
        res.last = 1'b1;
        due_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatch_cnt < PRINT_CAP)
      $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Offer one request after a random gap, hold it until taken, then predict
  task automatic send_request(input logic act, input logic [ID_W-1:0] id,
                              input logic [BYTE_W-1:0] rx);
    int gap;
    bit ignored;
    gap     = steady ? 0 : idle_len();
    ignored = (act == ACT_REQUEST) ? !mask_q[id] : !eng_busy;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_DATA_W - BYTE_W - ID_W){1'b0}}, rx, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!ignored) items_done++;
    advance_lin_engine(act, id, rx);
  endtask

  // Finish any frame in progress, drain, then write the accept mask
  task automatic write_mask(input logic [MASK_W-1:0] mask);
    while (eng_busy || fifo_cnt > 0) begin
      send_request(ACT_RX_BYTE, ID_W'($urandom_range(0, 63)),
                   (rx_cnt == bytes_for(cur_id)) ? sum_acc : bus_byte());
      keep_prediction();
    end
    in_tvalid <= 1'b0;
    while (due_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mask_q    = mask;
  endtask

  // Mostly well-formed frames with random content, plus noise and bad checksums
  task automatic run_phase(input logic [MASK_W-1:0] mask, input int goal,
                           input bit no_gaps, input int hold_at);
    int              start;
    int              tries;
    int              roll;
    logic            act;
    logic [ID_W-1:0] id;
    logic [BYTE_W-1:0] rx;
    write_mask(mask);
    steady = no_gaps;
    start  = items_done;
    tries  = 0;
    while ((items_done - start < goal || tries < 12) && tries < 4 * goal + 12) begin
      if (tries == hold_at) hold_off_req = 1'b1;
      tries++;
      roll = $urandom_range(0, 99);
      // burst of requests while busy to overflow the request queue
      if (eng_busy && roll < 2) begin
        repeat ($urandom_range(9, 12)) begin
          send_request(ACT_REQUEST, accepted_id(), bus_byte());
          keep_prediction();
        end
      end else begin
        id = ID_W'($urandom_range(0, 63));
        rx = bus_byte();
        if (eng_busy) begin
          act = (roll < 12) ? ACT_REQUEST : ACT_RX_BYTE;
          if (roll < 9) id = accepted_id();
          if (act == ACT_RX_BYTE && rx_cnt == bytes_for(cur_id) && roll < 87) rx = sum_acc;
        end else begin
          act = (roll < 80) ? ACT_REQUEST : ACT_RX_BYTE;
          if (roll < 65) id = accepted_id();
        end
        send_request(act, id, rx);
        keep_prediction();
      end
    end
  endtask

  // Result receiver: random stalls, steady stretches, one long hold-off
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = idle_len();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin
    lin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing due", out_tdata[DATA_W-1:0], '0);
      end else begin
        want = due_results.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("kind", DATA_W'(out_tuser), DATA_W'(want.kind));
        if (out_tdata[BYTE_W-1:0] !== want.tx)
          report_mismatch("tx_byte", DATA_W'(out_tdata[BYTE_W-1:0]), DATA_W'(want.tx));
        if (out_tdata[FID_LO +: ID_W] !== want.fid)
          report_mismatch("frame_id", DATA_W'(out_tdata[FID_LO +: ID_W]), DATA_W'(want.fid));
        if (out_tdata[DATA_LO +: DATA_W] !== want.data)
          report_mismatch("frame_data", out_tdata[DATA_LO +: DATA_W], want.data);
        if (out_tdata[LEN_LO +: LEN_W] !== want.len)
          report_mismatch("data_len", DATA_W'(out_tdata[LEN_LO +: LEN_W]), DATA_W'(want.len));
        if (out_tlast !== want.last)
          report_mismatch("last", DATA_W'(out_tlast), DATA_W'(want.last));
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("lin_master_frame_engine_core: mismatch");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; open the mask fully once the reset checks are done
    for (int i = 0; i < N_ROWS; i++) begin
      row = DIRECTED[i];
      if (i == N_RESET_ROWS) write_mask('1);
      for (int r = 0; r < row.rep; r++) begin
        send_request(row.act, row.id, row.rx);
        if (row.chk == CHK_MODEL) keep_prediction();
        else queue_typed(row);
      end
    end

    // random phases over several masks, extremes included
    run_phase('1, 170, 1'b0, 40);
    run_phase('0, 0, 1'b0, -1);
    run_phase({32{2'b10}}, 80, 1'b1, -1);
    run_phase({32{2'b01}}, 60, 1'b0, -1);
    run_phase({1'b1, 62'd0, 1'b1}, 30, 1'b0, -1);
    run_phase({$urandom, $urandom}, 80, 1'b0, -1);

    in_tvalid <= 1'b0;
    while (due_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0) $display("lin_master_frame_engine_core: match");
    else $display("lin_master_frame_engine_core: mismatch");
    $finish;
  end

endmodule
